// ----- rtl/hid_keyboard_report_keeper_unit_defines.svh -----
// assertion helpers used by the report keeper rtl
`ifndef HID_KEYBOARD_REPORT_KEEPER_UNIT_DEFINES_SVH
`define HID_KEYBOARD_REPORT_KEEPER_UNIT_DEFINES_SVH

// same-cycle implication
`define HKRK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hkrk check failed");

// next-cycle implication
`define HKRK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hkrk check failed");

`endif

// ----- rtl/hkrk_pkg.sv -----
`default_nettype none

package hkrk_pkg;

    localparam int KEY_W     = 8;
    localparam int OUT_SLOTS = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = KEY_W * (OUT_SLOTS + 1);

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [KEY_W-1:0] MOD_FIRST = 8'hE0;
    localparam logic [KEY_W-1:0] MOD_END   = 8'hE8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic             press;
        logic [KEY_W-1:0] key;
    } t_walk_cmd;

endpackage

`default_nettype wire

// ----- rtl/hid_keyboard_report_keeper_unit.sv -----
// Keeps a boot keyboard report: modifier byte plus SLOT_COUNT key slots, newest
// in slot 0. Each input word (op, key) gives one output word holding the report
// after the operation: modifiers in bits 7:0, then slot0 to slot5 a byte each.
// A press of a nonzero non-modifier key or a release of a nonzero key walks the
// slots through one shared compare unit, one slot per cycle; every other word
// skips the walk. The input side is held off while a word is in work.
// A finished report waits in the output register and does not stop the
// next word being taken.
`default_nettype none

module hid_keyboard_report_keeper_unit #(
    parameter int SLOT_COUNT = 6
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // op, key, zero pad
    input  wire  [hkrk_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // modifiers, slot0, slot1, slot2, slot3, slot4, slot5
    output logic [hkrk_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

`include "hid_keyboard_report_keeper_unit_defines.svh"

    localparam int KW = hkrk_pkg::KEY_W;

    hkrk_pkg::t_state r_state;
    hkrk_pkg::t_state n_state;

    logic [KW-1:0]                   r_mod;
    logic [KW-1:0]                   n_mod;
    logic [SLOT_COUNT-1:0][KW-1:0]   r_slots;
    logic [SLOT_COUNT-1:0][KW-1:0]   n_slots;
    logic [1:0]                      r_op;
    logic [KW-1:0]                   r_key;
    logic                            r_out_valid;
    logic [hkrk_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [hkrk_pkg::OUT_DATA_W-1:0] n_out_data;

    logic [1:0]                      w_in_op;
    logic [KW-1:0]                   w_in_key;
    logic                            w_in_mod;
    logic                            w_accept;
    logic                            w_need_walk;
    logic                            w_ready;
    logic                            w_load;
    logic                            w_key_mod;
    logic [KW-1:0]                   w_mod_bit;
    logic                            w_done;
    logic [SLOT_COUNT-1:0][KW-1:0]   w_walk_slots;
    hkrk_pkg::t_walk_cmd             w_cmd;

    assign w_in_op  = i_s_axis_tdata[1:0];
    assign w_in_key = i_s_axis_tdata[KW+1:2];
    assign w_in_mod = (w_in_key >= hkrk_pkg::MOD_FIRST) && (w_in_key < hkrk_pkg::MOD_END);
    assign w_accept = i_s_axis_tvalid && w_ready;

    assign w_need_walk = (w_in_key != '0) &&
                         (((w_in_op == hkrk_pkg::OP_PRESS) && !w_in_mod) ||
                          (w_in_op == hkrk_pkg::OP_RELEASE));

    assign w_key_mod = (r_key >= hkrk_pkg::MOD_FIRST) && (r_key < hkrk_pkg::MOD_END);
    assign w_mod_bit = KW'(1) << r_key[2:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hkrk_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_walk ? hkrk_pkg::ST_WALK : hkrk_pkg::ST_FIN;
                end
            end
            hkrk_pkg::ST_WALK: begin
                if (w_done) begin
                    n_state = hkrk_pkg::ST_FIN;
                end
            end
            hkrk_pkg::ST_FIN: begin
                if (w_load) begin
                    n_state = hkrk_pkg::ST_IDLE;
                end
            end
            default: n_state = hkrk_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready     = 1'b0;
        w_load      = 1'b0;
        w_cmd.start = 1'b0;
        w_cmd.press = (w_in_op == hkrk_pkg::OP_PRESS);
        w_cmd.key   = w_in_key;
        unique case (r_state)
            hkrk_pkg::ST_IDLE: begin
                w_ready     = 1'b1;
                w_cmd.start = i_s_axis_tvalid && w_need_walk;
            end
            hkrk_pkg::ST_WALK: begin
            end
            hkrk_pkg::ST_FIN: begin
                w_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    hkrk_slot_walk #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_slots (r_slots),
        .o_done  (w_done),
        .o_slots (w_walk_slots)
    );

    // report after the operation
    always_comb begin
        n_mod   = r_mod;
        n_slots = r_slots;
        unique case (r_op)
            hkrk_pkg::OP_PRESS: begin
                if (w_key_mod) begin
                    n_mod = r_mod | w_mod_bit;
                end else if (r_key != '0) begin
                    n_slots = w_walk_slots;
                end
            end
            hkrk_pkg::OP_RELEASE: begin
                if (r_key != '0) begin
                    if (w_key_mod) begin
                        n_mod = r_mod & ~w_mod_bit;
                    end
                    n_slots = w_walk_slots;
                end
            end
            hkrk_pkg::OP_CLEAR: begin
                n_slots = '0;
            end
            default: begin
            end
        endcase
    end

    assign n_out_data[KW-1:0] = n_mod;

    for (genvar g = 0; g < hkrk_pkg::OUT_SLOTS; g++) begin : g_out
        if (g < SLOT_COUNT) begin : g_used
            assign n_out_data[KW*(g+1) +: KW] = n_slots[g];
        end else begin : g_empty
            assign n_out_data[KW*(g+1) +: KW] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hkrk_pkg::ST_IDLE;
            r_mod       <= '0;
            r_slots     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_mod       <= n_mod;
                r_slots     <= n_slots;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= w_in_op;
            r_key <= w_in_key;
        end
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `HKRK_ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n,
        w_accept && w_need_walk, r_state == hkrk_pkg::ST_WALK)
    `HKRK_ASSERT_NOW(a_done_in_walk, i_clk, i_rst_n,
        w_done, r_state == hkrk_pkg::ST_WALK)
    `HKRK_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n,
        w_load, o_m_axis_tvalid && (r_state == hkrk_pkg::ST_IDLE))

endmodule

`default_nettype wire

// ----- rtl/hkrk_slot_walk.sv -----
`default_nettype none

module hkrk_slot_walk #(
    parameter int SLOT_COUNT = 6
) (
    input  wire                                           i_clk,
    input  wire                                           i_rst_n,
    input  wire  hkrk_pkg::t_walk_cmd                     i_cmd,
    input  wire  [SLOT_COUNT-1:0][hkrk_pkg::KEY_W-1:0]    i_slots,
    output logic                                          o_done,
    output logic [SLOT_COUNT-1:0][hkrk_pkg::KEY_W-1:0]    o_slots
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_W = SLOT_COUNT * hkrk_pkg::KEY_W;

    logic                                       r_busy;
    logic                                       r_done;
    logic [IDX_W-1:0]                           r_cnt;
    logic [CNT_W-1:0]                           r_dst;
    logic [hkrk_pkg::KEY_W-1:0]                 r_key;
    logic [SLOT_COUNT-1:0][hkrk_pkg::KEY_W-1:0] r_src;
    logic [SLOT_COUNT-1:0][hkrk_pkg::KEY_W-1:0] r_work;

    logic [hkrk_pkg::KEY_W-1:0] w_head;
    logic                       w_keep;

    // one compare per cycle during a walk, against the newest unvisited slot
    assign w_head = r_src[0];
    assign w_keep = (w_head != r_key) && (r_dst < CNT_W'(SLOT_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == IDX_W'(SLOT_COUNT - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_src <= i_slots;
            r_key <= i_cmd.key;
            r_cnt <= '0;
            if (i_cmd.press) begin
                r_work <= SLOT_W'(i_cmd.key);
                r_dst  <= CNT_W'(1);
            end else begin
                r_work <= '0;
                r_dst  <= '0;
            end
        end else if (r_busy) begin
            r_src <= r_src >> hkrk_pkg::KEY_W;
            r_cnt <= r_cnt + IDX_W'(1);
            if (w_keep) begin
                r_work[r_dst[IDX_W-1:0]] <= w_head;
                r_dst                    <= r_dst + CNT_W'(1);
            end
        end
    end

    assign o_done  = r_done;
    assign o_slots = r_work;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

    import hkrk_pkg::*;

    localparam int SLOT_COUNT  = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 400;
    localparam int DRAIN_WAIT  = 20;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [OUT_SLOTS-1:0][KEY_W-1:0] slots;
        logic [KEY_W-1:0]                modifiers;
    } t_report;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic             fixed;
        t_report          report;
    } t_row;

    localparam int ROW_COUNT = 24;
    localparam t_row DIRECTED_ROWS [ROW_COUNT] = '{
        '{OP_PRESS,   8'h00, 1'b1, 56'h00},
        '{OP_RELEASE, 8'h00, 1'b1, 56'h00},
        '{OP_NOP,     8'hFF, 1'b1, 56'h00},
        '{OP_CLEAR,   8'h5A, 1'b1, 56'h00},
        '{OP_PRESS,   8'hE0, 1'b1, 56'h01},
        '{OP_PRESS,   8'hE7, 1'b1, 56'h81},
        '{OP_RELEASE, 8'hE0, 1'b1, 56'h80},
        '{OP_PRESS,   8'hFF, 1'b0, 56'h00},
        '{OP_PRESS,   8'h01, 1'b0, 56'h00},
        '{OP_PRESS,   8'h04, 1'b0, 56'h00},
        '{OP_PRESS,   8'h05, 1'b0, 56'h00},
        '{OP_PRESS,   8'h06, 1'b0, 56'h00},
        '{OP_PRESS,   8'h07, 1'b0, 56'h00},
        '{OP_PRESS,   8'h08, 1'b0, 56'h00},
        '{OP_PRESS,   8'h05, 1'b0, 56'h00},
        '{OP_RELEASE, 8'h01, 1'b0, 56'h00},
        '{OP_RELEASE, 8'h99, 1'b0, 56'h00},
        '{OP_PRESS,   8'hE8, 1'b0, 56'h00},
        '{OP_PRESS,   8'hDF, 1'b0, 56'h00},
        '{OP_NOP,     8'h55, 1'b0, 56'h00},
        '{OP_RELEASE, 8'hE7, 1'b0, 56'h00},
        '{OP_RELEASE, 8'hE8, 1'b0, 56'h00},
        '{OP_CLEAR,   8'hFF, 1'b0, 56'h00},
        '{OP_RELEASE, 8'h04, 1'b0, 56'h00}
    };

    localparam int POOL_SIZE = 10;
    localparam logic [KEY_W-1:0] KEY_POOL [POOL_SIZE] = '{
        8'h04, 8'h05, 8'h06, 8'h07, 8'h1E, 8'h28, 8'h2C, 8'h4F, 8'h80, 8'hFF
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    logic [KEY_W-1:0] held_mods;
    logic [KEY_W-1:0] held_slots [SLOT_COUNT];
    t_report          expected_reports [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               send_idle_pct = 37;
    int               recv_idle_pct = 85;

    hid_keyboard_report_keeper_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic void drop_key(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] kept [SLOT_COUNT];
        int n;
        n = 0;
        for (int i = 0; i < SLOT_COUNT; i++) kept[i] = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (held_slots[i] != key) begin
                kept[n] = held_slots[i];
                n++;
            end
        end
        held_slots = kept;
    endfunction

    function automatic t_report apply_key_event(input logic [1:0] op,
                                                input logic [KEY_W-1:0] key);
        t_report report;
        logic    is_mod;
        is_mod = (key >= MOD_FIRST) && (key < MOD_END);
        case (op)
            OP_PRESS: begin
                if (is_mod) begin
                    held_mods[key - MOD_FIRST] = 1'b1;
                end else if (key != '0) begin
                    drop_key(key);
                    for (int i = SLOT_COUNT - 1; i > 0; i--) held_slots[i] = held_slots[i-1];
                    held_slots[0] = key;
                end
            end
            OP_RELEASE: begin
                if (key != '0) begin
                    if (is_mod) held_mods[key - MOD_FIRST] = 1'b0;
                    drop_key(key);
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOT_COUNT; i++) held_slots[i] = '0;
            end
            default: ;
        endcase
        report = '0;
        report.modifiers = held_mods;
        for (int i = 0; i < OUT_SLOTS; i++) begin
            if (i < SLOT_COUNT) report.slots[i] = held_slots[i];
        end
        return report;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] key,
                             input logic fixed, input t_report fixed_report);
        t_report predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W - KEY_W - 2){1'b0}}, key, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = apply_key_event(op, key);
        expected_reports.push_back(fixed ? fixed_report : predicted);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return KEY_POOL[$urandom_range(POOL_SIZE - 1)];
        if (roll < 80) return MOD_FIRST + KEY_W'($urandom_range(7));
        return KEY_W'($urandom_range(255));
    endfunction

    function automatic logic [1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return OP_PRESS;
        if (roll < 88) return OP_RELEASE;
        if (roll < 96) return OP_CLEAR;
        return OP_NOP;
    endfunction

    // output side: random stall and report check
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_reports.size() == 0) begin
                flag_error($sformatf("unexpected word %h", got));
            end else begin
                want = expected_reports.pop_front();
                if (got.modifiers !== want.modifiers)
                    flag_error($sformatf("modifiers: got %h want %h",
                                         got.modifiers, want.modifiers));
                for (int i = 0; i < OUT_SLOTS; i++) begin
                    if (got.slots[i] !== want.slots[i])
                        flag_error($sformatf("slot%0d: got %h want %h",
                                             i, got.slots[i], want.slots[i]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hid_keyboard_report_keeper_unit test failed");
            $finish;
        end
    end

    initial begin
        held_mods = '0;
        for (int i = 0; i < SLOT_COUNT; i++) held_slots[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < ROW_COUNT; r++)
            send_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key,
                      DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].report);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 37; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(pick_op(), pick_key(), 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("hid_keyboard_report_keeper_unit test passed");
        end else begin
            $display("hid_keyboard_report_keeper_unit test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hkrk_pkg.sv
rtl/hkrk_slot_walk.sv
rtl/hid_keyboard_report_keeper_unit.sv
verif/tb.sv
